>>> rtl/sc_pkg.sv
// Shared constants, codes and types for the stack calculator.
`timescale 1ns / 1ps
`default_nettype none
package sc_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int DEPTH_W = 11;
    localparam int POS_W = 10;

    typedef enum logic [2:0] {
        MODE_PUSH = 3'd0, MODE_POP = 3'd1, MODE_PEEK_TOP = 3'd2, MODE_PEEK_BOT = 3'd3,
        MODE_ADD = 3'd4, MODE_SUB = 3'd5, MODE_MUL = 3'd6, MODE_DIV = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_RANGE = 3'd3,
        ST_FEW = 3'd4, ST_DIVZERO = 3'd5
    } status_t;
endpackage
`default_nettype wire

>>> rtl/sc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> rtl/sc_divider.sv
// Iterative floor divider for signed words, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sc_divider import sc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] num,
    input  wire logic [WORD_W-1:0] den,
    output logic                   done,
    output logic      [WORD_W-1:0] quo
);
    logic [WORD_W-1:0] q_reg, d_reg;
    logic [WORD_W:0]   r_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg, neg_reg, done_reg;
    logic [WORD_W:0]   r_shift;
    logic [WORD_W:0]   r_sub;

    assign r_shift = {r_reg[WORD_W-1:0], q_reg[WORD_W-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};

    // Restoring division on magnitudes; sign fixed at the end for floor rounding.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                neg_reg  <= num[WORD_W-1] ^ den[WORD_W-1];
                q_reg    <= num[WORD_W-1] ? (~num + 1'b1) : num;
                d_reg    <= den[WORD_W-1] ? (~den + 1'b1) : den;
                r_reg    <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == 6'(WORD_W)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (neg_reg) begin
                        q_reg <= ~q_reg + 1'b1 - {31'd0, (r_reg != '0)};
                    end
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (!r_sub[WORD_W]) begin
                        r_reg <= r_sub;
                        q_reg <= {q_reg[WORD_W-2:0], 1'b1};
                    end else begin
                        r_reg <= r_shift;
                        q_reg <= {q_reg[WORD_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

>>> rtl/stack_calculator.sv
// Top level of the stack calculator: command sequencer around the stack memory.
//
// The block takes one command item on the s_axis channel and returns exactly one
// result item on the m_axis channel. Commands: push, pop, peek from the top, peek
// from the bottom, add, subtract, multiply and floor divide on the top two words.
// The stack words live in a 1024-entry synchronous RAM; the depth is a register.
// One item is worked on at a time. Push and commands rejected on the depth check
// go from decode straight to the result, pop and peeks take one RAM read, a
// divide by zero stops after two RAM reads, add and subtract take two RAM reads
// then write-back, multiply adds a registered product before write-back, and
// divide waits for the one-bit-per-cycle divider. The next item can be
// accepted in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, the next
// item is accepted and worked on up to its result, which then waits.
// Reset (aresetn low, synchronous) empties the stack; no clearing pass is needed
// because only written entries below the depth are ever read.
`timescale 1ns / 1ps
`default_nettype none
module stack_calculator import sc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: mode[2:0], push_value[34:3], position[44:35], zero fill.
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: result_value[31:0], status[34:32], depth[45:35], zero fill.
    output logic      [47:0] m_axis_tdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD1, S_RD2, S_RD3, S_MUL, S_DIV, S_WB, S_DONE
    } state_t;

    state_t            state_reg;
    mode_t             mode_reg;
    logic [WORD_W-1:0] val_reg, top_reg, res_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  count_reg;
    status_t           status_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;
    logic [63:0]       prod_reg;
    logic              div_start;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [WORD_W-1:0] div_quo;
    logic              div_done;
    logic [CNT_W-1:0]  pos_ext;

    assign pos_ext = CNT_W'(pos_reg);

    sc_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    sc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(ram_rdata),
        .den(top_reg), .done(div_done), .quo(div_quo)
    );

    // Memory read address per state.
    always_comb begin
        case (state_reg)
            S_DECODE: begin
                case (mode_reg)
                    MODE_PEEK_TOP: ram_raddr = ADDR_W'(count_reg - 1'b1 - pos_ext);
                    MODE_PEEK_BOT: ram_raddr = ADDR_W'(pos_reg);
                    default:       ram_raddr = ADDR_W'(count_reg - 1'b1);
                endcase
            end
            default: ram_raddr = ADDR_W'(count_reg - 1'b1);
        endcase
    end

    // Memory writes for push and arithmetic write-back.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(count_reg);
        ram_wdata = val_reg;
        if (state_reg == S_DECODE && mode_reg == MODE_PUSH && count_reg < CNT_W'(STACK_DEPTH)) begin
            ram_we = 1'b1;
        end else if (state_reg == S_WB) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(count_reg - 2'd2);
            ram_wdata = res_reg;
        end
    end

    assign div_start     = (state_reg == S_RD3) && (mode_reg == MODE_DIV) && (top_reg != '0);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Command sequencer, state registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // Output valid: set when a result is loaded, cleared once taken.
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        mode_reg   <= mode_t'(s_axis_tdata[2:0]);
                        val_reg    <= s_axis_tdata[34:3];
                        pos_reg    <= s_axis_tdata[44:35];
                        res_reg    <= '0;
                        status_reg <= ST_OK;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (mode_reg)
                        MODE_PUSH: begin
                            if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                                status_reg <= ST_FULL;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= S_DONE;
                        end
                        MODE_POP: begin
                            if (count_reg == '0) begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_DONE;
                            end else begin
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_RD1;
                            end
                        end
                        MODE_PEEK_TOP, MODE_PEEK_BOT: begin
                            if (pos_ext >= count_reg) begin
                                status_reg <= ST_RANGE;
                                state_reg  <= S_DONE;
                            end else begin
                                state_reg <= S_RD1;
                            end
                        end
                        default: begin
                            if (count_reg < CNT_W'(2)) begin
                                status_reg <= ST_FEW;
                                state_reg  <= S_DONE;
                            end else begin
                                // Step the depth down once so the next read hits the second word.
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_RD2;
                            end
                        end
                    endcase
                end
                S_RD1: begin
                    res_reg   <= ram_rdata;
                    state_reg <= S_DONE;
                end
                S_RD2: begin
                    top_reg   <= ram_rdata;
                    state_reg <= S_RD3;
                end
                S_RD3: begin
                    // ram_rdata is the second word; count_reg is depth minus one here.
                    case (mode_reg)
                        MODE_ADD: begin
                            res_reg <= ram_rdata + top_reg;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_WB;
                        end
                        MODE_SUB: begin
                            res_reg <= ram_rdata - top_reg;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_WB;
                        end
                        MODE_MUL: begin
                            prod_reg  <= ram_rdata * top_reg;
                            state_reg <= S_MUL;
                        end
                        default: begin
                            if (top_reg == '0) begin
                                status_reg <= ST_DIVZERO;
                                count_reg  <= count_reg - 1'b1;
                                state_reg  <= S_DONE;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    res_reg   <= prod_reg[WORD_W-1:0];
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_WB;
                end
                S_DIV: begin
                    if (div_done) begin
                        res_reg   <= div_quo;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_WB;
                    end
                end
                S_WB: begin
                    // Write-back happens combinationally here; depth becomes old depth minus one.
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_data_reg  <= {2'b00, DEPTH_W'(count_reg), status_reg, res_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
